// File: hdl/hse_pkg.sv
package hse_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // Width of the value field on both stream ports
    localparam int VALUE_W = 32;

    // Result of one parent/children compare
    typedef struct packed {
        logic move;        // parent is less than the larger child
        logic pick_right;  // larger child is the right one (ties go right)
    } t_cmp_res;

    // Sequencer states
    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_RDP  = 9'b000000010,
        S_CAPP = 9'b000000100,
        S_CMP  = 9'b000001000,
        S_PUT  = 9'b000010000,
        S_SWP  = 9'b000100000,
        S_SWP2 = 9'b001000000,
        S_ORD  = 9'b010000000,
        S_OLD  = 9'b100000000
    } t_state;

endpackage

// File: hdl/hse_cmp.sv
module hse_cmp import hse_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic [W-1:0] i_sift,
    input  logic [W-1:0] i_left,
    input  logic [W-1:0] i_right,
    input  logic         i_right_ok,
    output logic [W-1:0] o_max,
    output t_cmp_res     o_res
);

    logic pick_right;

    // Larger child, right one wins on a tie; move only if the parent is smaller
    assign pick_right       = i_right_ok && !(i_left > i_right);
    assign o_max            = pick_right ? i_right : i_left;
    assign o_res.pick_right = pick_right;
    assign o_res.move       = (i_sift < o_max);

endmodule

// File: hdl/hse_store.sv
module hse_store import hse_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int W     = WORD_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_a,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_a;
    logic [W-1:0] r_rd_b;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// File: hdl/hse_out.sv
module hse_out import hse_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [W-1:0]       i_data,
    input  logic               i_last,
    output logic               o_free,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [VALUE_W-1:0] o_tdata,
    output logic               o_tlast
);

    logic         r_valid;
    logic [W-1:0] r_data;
    logic         r_last;

    assign o_free = !r_valid || i_tready;

    // Hold a result until the sink takes it; reload in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = VALUE_W'(r_data);
    assign o_tlast  = r_last;

endmodule

// File: hdl/heap_sort_engine_top.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata = value, tlast = is_last
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata = sorted_value, tlast = end_of_set
//
// Loading accepts one word per cycle; the input is ready only while loading.
// One compare unit then sorts in place over a store with one write and two read ports.
// Each sift reads its start word, compares once per level descended (once more if it stops
// above a leaf) and writes the word into the hole. Emitting reads each word, then loads it
// into the output register; a stalled output holds it, and the input stays stalled until the
// last result is in the output register. Reset empties the set and drops any pending output.
module heap_sort_engine_top import hse_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic               s_axis_tlast,   // is_last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic               m_axis_tlast    // end_of_set
);

    localparam int SW = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = CW + 1;

    t_state        r_state, n_state;
    logic          r_build, n_build;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_size,  n_size;
    logic [CW-1:0] r_i,     n_i;
    logic [CW-1:0] r_node,  n_node;
    logic [CW-1:0] r_k,     n_k;
    logic [SW-1:0] r_sift,  n_sift;

    logic          we;
    logic [AW-1:0] waddr;
    logic [SW-1:0] wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [SW-1:0] rd_a;
    logic [SW-1:0] rd_b;

    logic [KW-1:0] c_l;
    logic [KW-1:0] c_r;
    logic          right_ok;
    logic [SW-1:0] cmp_max;
    t_cmp_res      cmp_res;

    logic          out_load;
    logic          out_last;
    logic          out_free;

    // Children of the current node
    assign c_l      = {r_node, 1'b0};
    assign c_r      = c_l + 1'b1;
    assign right_ok = (c_r <= {1'b0, r_size});

    assign s_axis_tready = (r_state == S_LOAD);

    hse_store #(
        .DEPTH (DEPTH),
        .W     (SW),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    hse_cmp #(
        .W (SW)
    ) u_cmp (
        .i_sift     (r_sift),
        .i_left     (rd_a),
        .i_right    (rd_b),
        .i_right_ok (right_ok),
        .o_max      (cmp_max),
        .o_res      (cmp_res)
    );

    hse_out #(
        .W (SW)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_data   (rd_a),
        .i_last   (out_last),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    // Sequencer: load, build heap, sort by swap and sift, emit
    always_comb begin
        logic          do_desc;
        logic [CW-1:0] v_cnt;
        logic [CW-1:0] v_half;
        logic [CW-1:0] v_nm1;
        logic [CW-1:0] v_sm1;
        logic [CW-1:0] v_k1;
        logic [KW-1:0] v_l;
        logic [KW-1:0] v_lm1;

        n_state  = r_state;
        n_build  = r_build;
        n_count  = r_count;
        n_size   = r_size;
        n_i      = r_i;
        n_node   = r_node;
        n_k      = r_k;
        n_sift   = r_sift;
        we       = 1'b0;
        v_nm1    = r_node - 1'b1;
        v_sm1    = r_size - 1'b1;
        v_k1     = r_k + 1'b1;
        waddr    = v_nm1[AW-1:0];
        wdata    = r_sift;
        raddr_a  = r_k[AW-1:0];
        raddr_b  = '0;
        out_load = 1'b0;
        out_last = 1'b0;
        do_desc  = 1'b0;
        v_cnt    = r_count;
        v_half   = '0;

        case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    // Store the word unless the set is full
                    if (r_count < CW'(DEPTH)) begin
                        we    = 1'b1;
                        waddr = r_count[AW-1:0];
                        wdata = s_axis_tdata[SW-1:0];
                        v_cnt = CW'(r_count + 1'b1);
                    end
                    n_count = v_cnt;
                    if (s_axis_tlast) begin
                        v_half = v_cnt >> 1;
                        n_size = v_cnt;
                        if (v_half != '0) begin
                            n_build = 1'b1;
                            n_i     = v_half;
                            n_node  = v_half;
                            n_state = S_RDP;
                        end else begin
                            n_build = 1'b0;
                            n_state = S_SWP;
                        end
                    end
                end
            end
            S_RDP: begin
                raddr_a = v_nm1[AW-1:0];
                n_state = S_CAPP;
            end
            S_CAPP: begin
                n_sift  = rd_a;
                do_desc = 1'b1;
            end
            S_CMP: begin
                // Move the larger child up into the hole, or stop here
                if (cmp_res.move) begin
                    we      = 1'b1;
                    wdata   = cmp_max;
                    n_node  = cmp_res.pick_right ? c_r[CW-1:0] : c_l[CW-1:0];
                    do_desc = 1'b1;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                we = 1'b1;
                if (r_build) begin
                    if (r_i > CW'(1)) begin
                        n_i     = r_i - 1'b1;
                        n_node  = r_i - 1'b1;
                        n_state = S_RDP;
                    end else begin
                        n_build = 1'b0;
                        n_size  = r_count;
                        n_state = S_SWP;
                    end
                end else if (r_size == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_SWP;
                end
            end
            S_SWP: begin
                raddr_a = '0;
                raddr_b = v_sm1[AW-1:0];
                n_state = S_SWP2;
            end
            S_SWP2: begin
                // Old root goes to the end; the end word sifts down from the root
                we      = 1'b1;
                waddr   = v_sm1[AW-1:0];
                wdata   = rd_a;
                n_sift  = rd_b;
                n_size  = v_sm1;
                n_node  = CW'(1);
                do_desc = 1'b1;
            end
            S_ORD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = (v_k1 == r_count);
                    if (out_last) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = v_k1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // Descend: read both children of the next node, or finish the sift
        v_l   = {n_node, 1'b0};
        v_lm1 = v_l - 1'b1;
        if (do_desc) begin
            if (v_l > {1'b0, n_size}) begin
                n_state = S_PUT;
            end else begin
                raddr_a = v_lm1[AW-1:0];
                raddr_b = v_l[AW-1:0];
                n_state = S_CMP;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_build <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_build <= n_build;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_i    <= n_i;
        r_node <= n_node;
        r_k    <= n_k;
        r_sift <= n_sift;
    end

endmodule
